// ===== rtl/core/positional_array_list_core_defines.svh =====
// assertion macros shared by the list core rtl
// no dependencies; included by files that carry assertions
`ifndef POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define PAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pal assertion failed");

// next-cycle implication, disabled while reset is high
`define PAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pal assertion failed");

`endif

// ===== rtl/core/pal_pkg.sv =====
// shared types and constants for the positional array list core
// no dependencies
`timescale 1ns / 1ps

package pal_pkg;

  // default number of list cells
  localparam int CAPACITY_DEF = 128;

  // cells gathered into one registered partial on a read
  localparam int GROUP_SIZE = 16;

  // field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int MOVED_W  = 7;
  localparam int CNTOUT_W = 8;
  localparam int STAT_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // shift control broadcast along the row of cells
  typedef struct packed {
    logic shift_up;
    logic shift_dn;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/pal_cell.sv =====
// one list cell: holds a single entry and trades it with its neighbours
// depends on pal_pkg
`timescale 1ns / 1ps

module pal_cell
  import pal_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CMP_W = 8
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic        [CMP_W-1:0] pos,
  input  logic signed [VAL_W-1:0] value_in,
  input  logic signed [VAL_W-1:0] from_below,
  input  logic signed [VAL_W-1:0] from_above,
  output logic signed [VAL_W-1:0] data,
  output logic signed [VAL_W-1:0] tap
);

  logic hit;
  logic above;

  // where this cell sits relative to the request position
  assign hit   = (pos == CMP_W'(IDX));
  assign above = (CMP_W'(IDX) > pos);

  // insert takes the new value or the lower neighbour, delete the upper one
  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      if (hit) begin
        data <= value_in;
      end else if (above) begin
        data <= from_below;
      end
    end else if (ctrl.shift_dn) begin
      if (hit || above) begin
        data <= from_above;
      end
    end
  end

  // entry offered to the read gather
  assign tap = hit ? data : '0;

endmodule

// ===== rtl/core/positional_array_list_core.sv =====
// top level of the positional array list: control, row of cells, read gather
// depends on pal_pkg, pal_cell and positional_array_list_core_defines.svh
`timescale 1ns / 1ps
//
// Usage
//   Requests arrive on cmd, position and value_in and are taken at a rising
//   edge where start is high and busy is low. cmd selects insert, delete or
//   read (an unused code behaves as read).
//   Each request gives one result on value_out, moved, count_now and status,
//   marked by done for exactly one cycle; the receiver cannot stall it.
//   The result is on the ports after the shift state S_EXEC and the gather
//   state S_GATHER. busy is high in both and drops in the result cycle, so a
//   new request can be taken at the edge that ends it, and not earlier.
//   The gather state serves the read gather: the entries of the row of cells
//   are folded into registered group partials, then into the registered result.
//   Insert and delete shift the cells at and above the position in parallel.
//   A full list or a bad position gives an error status and leaves the list
//   unchanged. Reset empties the list and drops busy and done; entry storage
//   itself is not cleared.
//
module positional_array_list_core
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic        [CMD_W-1:0]    cmd,
  input  logic        [POS_W-1:0]    position,
  input  logic signed [VAL_W-1:0]    value_in,
  output logic                       done,
  output logic signed [VAL_W-1:0]    value_out,
  output logic        [MOVED_W-1:0]  moved,
  output logic        [CNTOUT_W-1:0] count_now,
  output logic        [STAT_W-1:0]   status
);

`include "positional_array_list_core_defines.svh"

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_GATHER = 3'b100
  } state_t;

  state_t                    state;
  logic        [CNT_W-1:0]   count;
  logic        [CNT_W-1:0]   count_next;
  logic                      ins_r;
  logic                      del_r;
  logic                      ok_r;
  logic        [CMP_W-1:0]   pos_r;
  logic signed [VAL_W-1:0]   val_r;
  logic        [MOVED_W-1:0] moved_r;
  logic        [STAT_W-1:0]  status_r;
  logic        [CNTOUT_W-1:0] count_now_r;

  logic                      accept;
  logic                      is_ins;
  logic                      is_del;
  logic        [CMP_W-1:0]   pos_w;
  logic        [CMP_W-1:0]   cnt_w;
  logic        [CMP_W-1:0]   count_next_w;
  logic        [CMP_W-1:0]   diff;
  logic        [STAT_W-1:0]  status_next;
  logic        [MOVED_W-1:0] moved_next;

  cell_ctrl_t                ctrl;
  logic signed [VAL_W-1:0]   cell_data [CAPACITY];
  logic signed [VAL_W-1:0]   cell_tap  [CAPACITY];
  logic signed [VAL_W-1:0]   group_or  [GROUPS];
  logic signed [VAL_W-1:0]   partial   [GROUPS];
  logic signed [VAL_W-1:0]   gathered;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // request decode and checks against the current count
  always_comb begin
    is_ins      = (cmd == CMD_INSERT);
    is_del      = (cmd == CMD_DELETE);
    pos_w       = CMP_W'(position);
    cnt_w       = CMP_W'(count);
    status_next = ST_OK;
    moved_next  = '0;
    count_next  = count;
    diff        = cnt_w - pos_w;
    if (is_ins) begin
      if (count >= CNT_W'(CAPACITY)) begin
        status_next = ST_FULL;
      end else if (pos_w > cnt_w) begin
        status_next = ST_RANGE;
      end else begin
        moved_next = diff[MOVED_W-1:0];
        count_next = count + 1'b1;
      end
    end else begin
      if (pos_w >= cnt_w) begin
        status_next = ST_RANGE;
      end else if (is_del) begin
        moved_next = MOVED_W'(diff - 1'b1);
        count_next = count - 1'b1;
      end
    end
    count_next_w = CMP_W'(count_next);
  end

  // control sequence: accept, shift and sample, gather and report
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
            count <= count_next;
          end
        end
        S_EXEC: begin
          state <= S_GATHER;
        end
        S_GATHER: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ins_r       <= is_ins;
      del_r       <= is_del;
      ok_r        <= (status_next == ST_OK);
      pos_r       <= pos_w;
      val_r       <= value_in;
      moved_r     <= moved_next;
      status_r    <= status_next;
      count_now_r <= count_next_w[CNTOUT_W-1:0];
    end
  end

  // shift command to the row, only for a request that passed its checks
  always_comb begin
    ctrl.shift_up = (state == S_EXEC) && ok_r && ins_r;
    ctrl.shift_dn = (state == S_EXEC) && ok_r && del_r;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] below;
    logic signed [VAL_W-1:0] above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_inner_lo
      assign below = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above = '0;
    end else begin : g_inner_hi
      assign above = cell_data[i+1];
    end
    pal_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos_r),
      .value_in   (val_r),
      .from_below (below),
      .from_above (above),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // first gather level: one registered partial per group of cells
  for (genvar g = 0; g < GROUPS; g++) begin : g_group
    localparam int LO = g * GROUP_SIZE;
    localparam int N  = (CAPACITY - LO < GROUP_SIZE) ? (CAPACITY - LO) : GROUP_SIZE;
    always_comb begin
      group_or[g] = '0;
      for (int k = 0; k < N; k++) begin
        group_or[g] = group_or[g] | cell_tap[LO + k];
      end
    end
    always_ff @(posedge clk) begin
      if (state == S_EXEC) begin
        partial[g] <= group_or[g];
      end
    end
  end

  // second gather level
  always_comb begin
    gathered = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gathered = gathered | partial[g];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == S_GATHER) begin
      value_out <= (ok_r && !ins_r) ? gathered : '0;
      moved     <= moved_r;
      count_now <= count_now_r;
      status    <= status_r;
    end
  end

  // checks
  `PAL_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC && busy)
  `PAL_ASSERT_IMPL(a_done_not_busy, clk, rst, done, !busy)
  `PAL_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `PAL_ASSERT_IMPL(a_error_quiet, clk, rst, done && status != ST_OK, moved == '0 && value_out == '0)
  `PAL_ASSERT_IMPL(a_one_shift, clk, rst, 1'b1, !(ctrl.shift_up && ctrl.shift_dn))

endmodule
